@@ hw/rtl/ostt_pkg.sv @@
// package for the one-shot timer table: sizes, mode and result codes, sequencer states
// no dependencies; used by one_shot_timer_table_top and ostt_chk
`timescale 1ns / 1ps

package ostt_pkg;

  // default table size
  localparam int unsigned EntriesDefault = 16;

  // field widths fixed by the interface
  localparam int unsigned ModeW = 2;
  localparam int unsigned TimeW = 32;
  localparam int unsigned HandleW = 6;
  localparam int unsigned KindW = 3;

  // deadline reported when nothing is pending
  localparam logic [TimeW-1:0] NoDeadline = '1;

  // item modes
  localparam logic [ModeW-1:0] ModeSched  = 2'd0;
  localparam logic [ModeW-1:0] ModeCancel = 2'd1;
  localparam logic [ModeW-1:0] ModePoll   = 2'd2;
  localparam logic [ModeW-1:0] ModeIgnore = 2'd3;

  // result kinds
  localparam logic [KindW-1:0] KindScheduled = 3'd0;
  localparam logic [KindW-1:0] KindFull      = 3'd1;
  localparam logic [KindW-1:0] KindCancelled = 3'd2;
  localparam logic [KindW-1:0] KindExpired   = 3'd3;
  localparam logic [KindW-1:0] KindNone      = 3'd4;

  // sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEmit
  } ostt_state_e;

endpackage

@@ hw/rtl/one_shot_timer_table_top.sv @@
// one-shot timer table: slot scan sequencer, deadline memory, result emitter
// depends on ostt_pkg
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-------------------------------------------
// command   | in        | start_i, busy_o      | mode_i, now_ms_i, delay_ms_i, handle_i
// result    | out       | result_valid_o       | kind_o, slot_o, next_deadline_o, any_due_o,
//           |           |                      | last_o
//
// an item is taken at an edge with start_i high and busy_o low
// every item but mode three walks the whole table one slot a cycle through the
// single deadline memory read port: schedule and cancel give their result once
// the walk is done, and the next item can be taken at the edge ending that result
// a poll that expires timers then walks the fired mask one slot a cycle, up to
// the highest fired slot, giving one result per expired timer
// mode three is taken and dropped, busy_o stays low
// reset clears the busy bits and the sequencer at once; no clearing pass
// each result is shown for one cycle only, the receiver cannot stall it

module one_shot_timer_table_top #(
  parameter int unsigned ENTRIES = ostt_pkg::EntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command side
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ostt_pkg::ModeW-1:0]    mode_i,
  input  logic [ostt_pkg::TimeW-1:0]    now_ms_i,
  input  logic [ostt_pkg::TimeW-1:0]    delay_ms_i,
  input  logic [ostt_pkg::HandleW-1:0]  handle_i,
  // result side
  output logic                          result_valid_o,
  output logic [ostt_pkg::KindW-1:0]    kind_o,
  output logic [ostt_pkg::HandleW-1:0]  slot_o,
  output logic [ostt_pkg::TimeW-1:0]    next_deadline_o,
  output logic                          any_due_o,
  output logic                          last_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  // sequencer
  ostt_pkg::ostt_state_e state_q, state_d;

  // latched item
  logic [ostt_pkg::ModeW-1:0]   mode_q;
  logic [ostt_pkg::TimeW-1:0]   now_q;
  logic [ostt_pkg::TimeW-1:0]   sched_dl_q;
  logic [ostt_pkg::HandleW-1:0] handle_q;

  // read issue stage
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            rd_act_q, rd_act_d;

  // check stage, aligned with the registered memory read
  logic                      chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]           chk_idx_q, chk_idx_d;
  logic [ostt_pkg::TimeW-1:0] rdata_q;

  // table state
  logic [ENTRIES-1:0]         slot_busy_q, slot_busy_d;
  logic [ostt_pkg::TimeW-1:0] dl_mem [ENTRIES];
  logic                       mem_we;

  // scan accumulators
  logic [ostt_pkg::TimeW-1:0] min_q, min_d;
  logic                       due_q, due_d;
  logic                       placed_q, placed_d;
  logic [IdxW-1:0]            place_idx_q, place_idx_d;
  logic [ENTRIES-1:0]         fired_q, fired_d;
  logic                       any_fired_q, any_fired_d;
  logic [IdxW-1:0]            last_fired_q, last_fired_d;
  logic [IdxW-1:0]            em_idx_q, em_idx_d;

  // result registers
  logic                         res_vld_q, res_vld_d;
  logic [ostt_pkg::KindW-1:0]   kind_q, kind_d;
  logic [ostt_pkg::HandleW-1:0] slot_q, slot_d;
  logic                         last_q, last_d;

  // per-slot check of the shared compare unit
  logic                       chk_busy;
  logic                       place_now;
  logic                       contrib;
  logic [ostt_pkg::TimeW-1:0] cval;
  logic                       scan_end;
  logic                       take;

  assign take     = start_i && (state_q == ostt_pkg::StIdle);
  assign scan_end = chk_vld_q && (chk_idx_q == LastIdx);
  assign chk_busy = slot_busy_q[chk_idx_q];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ostt_pkg::StIdle: begin
        if (start_i && (mode_i != ostt_pkg::ModeIgnore)) begin
          state_d = ostt_pkg::StScan;
        end
      end
      ostt_pkg::StScan: begin
        if (scan_end) begin
          if ((mode_q == ostt_pkg::ModePoll) && any_fired_d) begin
            state_d = ostt_pkg::StEmit;
          end else begin
            state_d = ostt_pkg::StIdle;
          end
        end
      end
      ostt_pkg::StEmit: begin
        if (em_idx_q == last_fired_q) begin
          state_d = ostt_pkg::StIdle;
        end
      end
      default: state_d = ostt_pkg::StIdle;
    endcase
  end

  // slot check: what this slot adds to the summary and how it changes
  always_comb begin
    place_now = 1'b0;
    contrib   = 1'b0;
    cval      = rdata_q;
    if (chk_vld_q) begin
      unique case (mode_q)
        ostt_pkg::ModeSched: begin
          if (!chk_busy && !placed_q) begin
            place_now = 1'b1;
            contrib   = 1'b1;
            cval      = sched_dl_q;
          end else begin
            contrib = chk_busy;
          end
        end
        ostt_pkg::ModeCancel: begin
          contrib = chk_busy && (handle_q != ostt_pkg::HandleW'(chk_idx_q));
        end
        ostt_pkg::ModePoll: begin
          // anything due is freed here, so it never adds to the summary
          contrib = chk_busy && (now_q < rdata_q);
        end
        default: contrib = 1'b0;
      endcase
    end
  end

  assign mem_we = place_now;

  // datapath and result values
  always_comb begin
    rd_idx_d     = rd_idx_q;
    rd_act_d     = 1'b0;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    slot_busy_d  = slot_busy_q;
    min_d        = min_q;
    due_d        = due_q;
    placed_d     = placed_q;
    place_idx_d  = place_idx_q;
    fired_d      = fired_q;
    any_fired_d  = any_fired_q;
    last_fired_d = last_fired_q;
    em_idx_d     = em_idx_q;
    res_vld_d    = 1'b0;
    kind_d       = kind_q;
    slot_d       = slot_q;
    last_d       = last_q;

    unique case (state_q)
      ostt_pkg::StIdle: begin
        if (take) begin
          rd_idx_d    = '0;
          rd_act_d    = (mode_i != ostt_pkg::ModeIgnore);
          min_d       = ostt_pkg::NoDeadline;
          due_d       = 1'b0;
          placed_d    = 1'b0;
          fired_d     = '0;
          any_fired_d = 1'b0;
        end
      end
      ostt_pkg::StScan: begin
        // issue the next memory read
        if (rd_act_q) begin
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q;
          if (rd_idx_q != LastIdx) begin
            rd_act_d = 1'b1;
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        // update table and summary for the slot under check
        if (chk_vld_q) begin
          if (place_now) begin
            slot_busy_d[chk_idx_q] = 1'b1;
            placed_d               = 1'b1;
            place_idx_d            = chk_idx_q;
          end
          if ((mode_q == ostt_pkg::ModeCancel) &&
              (handle_q == ostt_pkg::HandleW'(chk_idx_q))) begin
            slot_busy_d[chk_idx_q] = 1'b0;
          end
          if ((mode_q == ostt_pkg::ModePoll) && chk_busy && (now_q >= rdata_q)) begin
            slot_busy_d[chk_idx_q] = 1'b0;
            fired_d[chk_idx_q]     = 1'b1;
            any_fired_d            = 1'b1;
            last_fired_d           = chk_idx_q;
          end
          if (contrib) begin
            if (cval < min_q) begin
              min_d = cval;
            end
            if (now_q >= cval) begin
              due_d = 1'b1;
            end
          end
        end
        // single result once the walk is done, unless a poll expired timers
        if (scan_end) begin
          em_idx_d = '0;
          if (!((mode_q == ostt_pkg::ModePoll) && any_fired_d)) begin
            res_vld_d = 1'b1;
            last_d    = 1'b1;
            slot_d    = '0;
            priority case (mode_q)
              ostt_pkg::ModeSched: begin
                if (placed_d) begin
                  kind_d = ostt_pkg::KindScheduled;
                  slot_d = ostt_pkg::HandleW'(place_idx_d);
                end else begin
                  kind_d = ostt_pkg::KindFull;
                end
              end
              ostt_pkg::ModeCancel: kind_d = ostt_pkg::KindCancelled;
              default:              kind_d = ostt_pkg::KindNone;
            endcase
          end
        end
      end
      ostt_pkg::StEmit: begin
        // walk the fired mask up to the highest fired slot
        if (fired_q[em_idx_q]) begin
          res_vld_d = 1'b1;
          kind_d    = ostt_pkg::KindExpired;
          slot_d    = ostt_pkg::HandleW'(em_idx_q);
          last_d    = (em_idx_q == last_fired_q);
        end
        if (em_idx_q != last_fired_q) begin
          em_idx_d = em_idx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ostt_pkg::StIdle;
      rd_act_q    <= 1'b0;
      chk_vld_q   <= 1'b0;
      slot_busy_q <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_act_q    <= rd_act_d;
      chk_vld_q   <= chk_vld_d;
      slot_busy_q <= slot_busy_d;
      res_vld_q   <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      mode_q     <= mode_i;
      now_q      <= now_ms_i;
      sched_dl_q <= now_ms_i + delay_ms_i;
      handle_q   <= handle_i;
    end
    rd_idx_q     <= rd_idx_d;
    chk_idx_q    <= chk_idx_d;
    min_q        <= min_d;
    due_q        <= due_d;
    placed_q     <= placed_d;
    place_idx_q  <= place_idx_d;
    fired_q      <= fired_d;
    any_fired_q  <= any_fired_d;
    last_fired_q <= last_fired_d;
    em_idx_q     <= em_idx_d;
    kind_q       <= kind_d;
    slot_q       <= slot_d;
    last_q       <= last_d;
  end

  // deadline memory: one write port at the check stage, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dl_mem[chk_idx_q] <= sched_dl_q;
    end
    rdata_q <= dl_mem[rd_idx_q];
  end

  assign busy_o          = (state_q != ostt_pkg::StIdle);
  assign result_valid_o  = res_vld_q;
  assign kind_o          = kind_q;
  assign slot_o          = slot_q;
  assign next_deadline_o = min_q;
  assign any_due_o       = due_q;
  assign last_o          = last_q;

endmodule

@@ hw/rtl/ostt_chk.sv @@
// port-level checker for the one-shot timer table, bound to the top level
// depends on ostt_pkg and one_shot_timer_table_top
`timescale 1ns / 1ps

module ostt_port_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [ostt_pkg::ModeW-1:0]    mode_i,
  input logic                          result_valid_o,
  input logic [ostt_pkg::KindW-1:0]    kind_o,
  input logic                          any_due_o,
  input logic                          last_o
);

  // a real command always makes the block busy
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (mode_i != ostt_pkg::ModeIgnore)) |=> busy_o)
    else $error("command item taken but block not busy");

  // only expired results come in runs
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o != ostt_pkg::KindExpired)) |-> last_o)
    else $error("single result without last");

  // a poll frees everything that is due
  a_poll_clears_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ((kind_o == ostt_pkg::KindExpired) ||
                        (kind_o == ostt_pkg::KindNone))) |-> !any_due_o)
    else $error("timer still due after poll");

  // more results follow, so no new item can be taken
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy_o)
    else $error("block idle in the middle of a result run");

endmodule

bind one_shot_timer_table_top ostt_port_chk u_ostt_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .mode_i         (mode_i),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .any_due_o      (any_due_o),
  .last_o         (last_o)
);
